### sv/spd_pkg.sv
// Shared types and constants of the scan plateau peak detector.
// No dependencies; used by every module of the block.
`default_nettype none

package spd_pkg;

  // Field widths of the sample and result items
  localparam int SAMPLE_W = 8;
  localparam int INDEX_W  = 15;
  localparam int VALUE_W  = 7;
  localparam int FREQ_W   = 32;
  localparam int STEP_W   = 24;
  localparam int COUNT_W  = 15;
  localparam int PROD_W   = INDEX_W + STEP_W;

  // Default sizing
  localparam int MAX_SCAN_LENGTH = 32768;
  localparam int QUEUE_DEPTH     = 4;  // power of two

  // Register map (index = paddr[2])
  localparam logic REG_START_FREQUENCY = 1'b0;
  localparam logic REG_FREQUENCY_STEP  = 1'b1;

  // Reset values of the registers
  localparam logic [FREQ_W-1:0] START_FREQUENCY_RESET = '0;
  localparam logic [STEP_W-1:0] FREQUENCY_STEP_RESET  = STEP_W'(1);

  // Classified result of one sample, passed from front to back
  typedef struct packed {
    logic               peak_valid;
    logic [INDEX_W-1:0] peak_index;
    logic [VALUE_W-1:0] peak_value;
    logic               scan_done;
    logic [COUNT_W-1:0] peak_count;
    logic               scan_error;
  } rec_t;

endpackage

`default_nettype wire

### sv/spd_front.sv
// Front end: accepts samples, tracks slope and plateau start, classifies peaks.
// Depends on spd_pkg; feeds spd_queue with one record per reported result.
`default_nettype none

module spd_front #(
  parameter int MAX_SCAN_LENGTH = spd_pkg::MAX_SCAN_LENGTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [spd_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                          last_sample,
  input  wire logic                          queue_full,
  output logic                               push,
  output spd_pkg::rec_t                      rec
);

  localparam logic [spd_pkg::INDEX_W-1:0] LAST_IDX =
    spd_pkg::INDEX_W'(MAX_SCAN_LENGTH - 1);

  logic signed [spd_pkg::SAMPLE_W-1:0] previous_sample;
  logic                                rising;
  logic [spd_pkg::INDEX_W-1:0]         plateau_start;
  logic [spd_pkg::INDEX_W-1:0]         sample_index;
  logic [spd_pkg::COUNT_W-1:0]         peaks_found;

  logic                                accept;
  logic                                at_end;
  logic                                rising_next;
  logic [spd_pkg::INDEX_W-1:0]         plateau_start_next;
  logic                                have_peak;
  logic                                keep_peak;
  logic [spd_pkg::INDEX_W-1:0]         peak_idx;
  logic signed [spd_pkg::SAMPLE_W-1:0] peak_val;
  logic [spd_pkg::INDEX_W-1:0]         fall_span;
  logic [spd_pkg::INDEX_W:0]           end_span;
  logic [spd_pkg::COUNT_W-1:0]         peaks_found_next;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign at_end   = last_sample || (sample_index >= LAST_IDX);

  // Slope tracking and peak placement at the plateau center
  always_comb begin
    rising_next        = rising;
    plateau_start_next = plateau_start;
    have_peak          = 1'b0;
    peak_idx           = '0;
    peak_val           = '0;
    fall_span          = sample_index - plateau_start;
    end_span           = '0;
    if (sample_index == '0) begin
      rising_next        = 1'b0;
      plateau_start_next = '0;
    end else begin
      if (previous_sample < sample) begin
        rising_next        = 1'b1;
        plateau_start_next = sample_index;
      end else if ((previous_sample > sample) && rising) begin
        have_peak   = 1'b1;
        peak_idx    = plateau_start + (fall_span >> 1);
        peak_val    = previous_sample;
        rising_next = 1'b0;
      end
      // scan ends on a rise or plateau: close it at the scan length
      if (at_end && rising_next) begin
        end_span  = {1'b0, sample_index} + (spd_pkg::INDEX_W+1)'(1)
                    - {1'b0, plateau_start_next};
        have_peak = 1'b1;
        peak_idx  = plateau_start_next + end_span[spd_pkg::INDEX_W:1];
        peak_val  = sample;
      end
    end
  end

  // Drop peaks that are not above zero
  assign keep_peak        = have_peak && (peak_val > 0);
  assign peaks_found_next = peaks_found + spd_pkg::COUNT_W'(keep_peak);

  // Build the record for the back end
  always_comb begin
    rec.peak_valid = keep_peak;
    rec.peak_index = keep_peak ? peak_idx : '0;
    rec.peak_value = keep_peak ? peak_val[spd_pkg::VALUE_W-1:0] : '0;
    rec.scan_done  = at_end;
    rec.peak_count = at_end ? peaks_found_next : '0;
    rec.scan_error = at_end && (sample_index == '0);
  end

  assign push = accept && (keep_peak || at_end);

  // Advance scan state; clear it after the last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      rising          <= 1'b0;
      plateau_start   <= '0;
      sample_index    <= '0;
      peaks_found     <= '0;
    end else if (accept) begin
      if (at_end) begin
        previous_sample <= '0;
        rising          <= 1'b0;
        plateau_start   <= '0;
        sample_index    <= '0;
        peaks_found     <= '0;
      end else begin
        previous_sample <= sample;
        rising          <= rising_next;
        plateau_start   <= plateau_start_next;
        sample_index    <= sample_index + spd_pkg::INDEX_W'(1);
        peaks_found     <= peaks_found_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/spd_queue.sv
// Short record queue between the classifying front end and the back end.
// Depends on spd_pkg for the record type.
`default_nettype none

module spd_queue #(
  parameter int QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire spd_pkg::rec_t push_rec,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output spd_pkg::rec_t      head_rec
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spd_pkg::rec_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = entries[rd_ptr];

  // Store records at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/spd_back.sv
// Back end: peak frequency (start + index * step, saturating) and output register.
// Depends on spd_pkg; drains spd_queue and drives the result stream.
`default_nettype none

module spd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [spd_pkg::FREQ_W-1:0]    start_frequency,
  input  wire logic [spd_pkg::STEP_W-1:0]    frequency_step,
  input  wire logic                          head_valid,
  input  wire spd_pkg::rec_t                 head_rec,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output spd_pkg::rec_t                      out_rec,
  output logic [spd_pkg::FREQ_W-1:0]         out_frequency
);

  logic                               mul_valid;
  spd_pkg::rec_t                      mul_rec;
  logic [spd_pkg::PROD_W-1:0]         mul_prod;
  logic                               mul_adv;
  logic [spd_pkg::PROD_W:0]           freq_sum;
  logic [spd_pkg::FREQ_W-1:0]         freq_sat;

  assign mul_adv = !out_valid || out_ready;
  assign pop     = head_valid && (!mul_valid || mul_adv);

  // Multiply stage: index times step
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (!mul_valid || mul_adv) begin
      mul_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mul_rec  <= head_rec;
      mul_prod <= spd_pkg::PROD_W'(head_rec.peak_index) * spd_pkg::PROD_W'(frequency_step);
    end
  end

  // Add start frequency and saturate
  assign freq_sum = (spd_pkg::PROD_W+1)'(start_frequency) + (spd_pkg::PROD_W+1)'(mul_prod);
  assign freq_sat = (freq_sum[spd_pkg::PROD_W:spd_pkg::FREQ_W] != '0) ? '1
                    : freq_sum[spd_pkg::FREQ_W-1:0];

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_adv) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_adv && mul_valid) begin
      out_rec       <= mul_rec;
      out_frequency <= mul_rec.peak_valid ? freq_sat : '0;
    end
  end

endmodule

`default_nettype wire

### sv/scan_plateau_peak_detector_top.sv
// Scan plateau peak detector: one sample accepted per cycle while the queue has room.
// A result goes through the queue write, the multiply stage and the add and saturate stage
// into the output register, where it waits for m_tready.
// Throughput: one sample per cycle; the input stalls only when the queue (4 entries by default) fills.
// Reset (synchronous, rst high) clears the scan state, the queue and both back stages;
// start_frequency returns to 0 and frequency_step to 1.
`default_nettype none

module scan_plateau_peak_detector_top #(
  parameter int MAX_SCAN_LENGTH = spd_pkg::MAX_SCAN_LENGTH,
  parameter int QUEUE_DEPTH     = spd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] sample
  input  wire logic        s_tlast,   // last_sample
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [14:0] peak_index, [21:15] peak_value,
                                      // [53:22] peak_frequency, [68:54] peak_count,
                                      // [69] scan_error, [71:70] zero
  output logic             m_tuser,   // peak_valid
  output logic             m_tlast,   // scan_done
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [spd_pkg::FREQ_W-1:0] start_frequency;
  logic [spd_pkg::STEP_W-1:0] frequency_step;
  logic                       cfg_write;

  logic                       q_push;
  spd_pkg::rec_t              q_push_rec;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_not_empty;
  spd_pkg::rec_t              q_head_rec;
  spd_pkg::rec_t              out_rec;
  logic [spd_pkg::FREQ_W-1:0] out_frequency;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frequency <= spd_pkg::START_FREQUENCY_RESET;
      frequency_step  <= spd_pkg::FREQUENCY_STEP_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        spd_pkg::REG_START_FREQUENCY: start_frequency <= pwdata[spd_pkg::FREQ_W-1:0];
        spd_pkg::REG_FREQUENCY_STEP:  frequency_step  <= pwdata[spd_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      spd_pkg::REG_START_FREQUENCY: prdata = start_frequency;
      spd_pkg::REG_FREQUENCY_STEP:  prdata = 32'(frequency_step);
      default:                      prdata = '0;
    endcase
  end

  spd_front #(
    .MAX_SCAN_LENGTH (MAX_SCAN_LENGTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sample      (s_tdata),
    .last_sample (s_tlast),
    .queue_full  (q_full),
    .push        (q_push),
    .rec         (q_push_rec)
  );

  spd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (q_push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (q_head_rec)
  );

  spd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .start_frequency (start_frequency),
    .frequency_step  (frequency_step),
    .head_valid      (q_not_empty),
    .head_rec        (q_head_rec),
    .pop             (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_rec         (out_rec),
    .out_frequency   (out_frequency)
  );

  // Pack the result beat
  assign m_tdata = {2'b00, out_rec.scan_error, out_rec.peak_count, out_frequency,
                    out_rec.peak_value, out_rec.peak_index};
  assign m_tuser = out_rec.peak_valid;
  assign m_tlast = out_rec.scan_done;

`ifndef SYNTHESIS
  // A reported peak always has a positive level
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[21:15] != '0))
    else $error("peak reported with zero level");

  // A short-scan error closes the scan and carries no peak
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[69]) |-> (m_tlast && !m_tuser && (m_tdata[68:54] == '0)))
    else $error("scan error beat malformed");

  // Input is refused only while the queue is full
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full)
    else $error("input stalled with queue space left");

  // A beat without a peak carries no frequency
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[53:22] == '0))
    else $error("frequency on a beat without a peak");
`endif

endmodule

`default_nettype wire
